/* rtl/htbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htbd_pkg
// Types and codes shared by the Huffman tree bit decoder: the item and result
// layouts, operation, status and register codes, and the fetch sequencer.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int IDX_W = 9;
	localparam int SYM_W = 8;
	localparam int STAT_W = 3;
	localparam int CNT_W = 48;
	localparam int CFG_W = 48;
	localparam int CFG_IDX_W = 1;

	localparam logic [IDX_W-1:0] NULL_CHILD = 9'd511;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [STAT_W-1:0] ST_NONE = 3'd0;
	localparam logic [STAT_W-1:0] ST_SYMBOL = 3'd1;
	localparam logic [STAT_W-1:0] ST_LAST = 3'd2;
	localparam logic [STAT_W-1:0] ST_CORRUPT = 3'd3;
	localparam logic [STAT_W-1:0] ST_HALTED = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 1'd1;

	typedef struct packed {
		logic operation;
		logic [IDX_W-1:0] node_index;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] right_child;
		logic leaf_flag;
		logic [SYM_W-1:0] leaf_symbol;
		logic coded_bit;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [STAT_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] pos0;
		logic [IDX_W-1:0] pos1;
		logic bad0;
		logic bad1;
	} kids_t;

	typedef enum logic [1:0] {
		SEQ_ROOT,
		SEQ_KIDS,
		SEQ_RUN
	} seq_t;

endpackage

`default_nettype wire

/* rtl/huffman_tree_bit_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Walks a Huffman tree held in a node memory, one coded bit per transfer.
// Results go to the output register, or to a skid register while it stalls.
// One load or decode per cycle, decodes only while the skid is free; the node
// memory is read one level ahead through two read ports, so a decode right
// after a load waits while the prefetched children are read again. After
// reset or a register write, SEQ_ROOT and SEQ_KIDS fetch the root and the
// children of the current node before decodes; reset does not clear the store.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder #(
	parameter int MAX_NODES = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire htbd_pkg::item_t                      item,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output htbd_pkg::result_t                         result,
	input  wire logic                                 wr_en,
	input  wire logic [htbd_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [htbd_pkg::CFG_W-1:0]           wr_data
);
	import htbd_pkg::*;

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int MEM_DEPTH = 1 << AW;
	localparam int EW = 2 * IDX_W + 1 + SYMBOL_BITS;

	logic [EW-1:0] mem [MEM_DEPTH];
	logic [EW-1:0] rd0_q, rd1_q;
	logic [AW-1:0] raddr0, raddr1;

	logic [IDX_W-1:0] node_count_q;
	logic [CNT_W-1:0] exp_m1_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] current_node_q, current_node_d;
	logic at_root_q, at_root_d;
	logic halted_q, halted_d;
	seq_t seq_q, seq_d;
	logic pf_ok_q, pf_ok_d;
	kids_t kids_q, kids_d;
	logic [IDX_W-1:0] root_l_q, root_r_q, root_l_d, root_r_d;

	logic rv_q, sv_q;
	result_t res_q, skid_q, res_new;

	logic [IDX_W-1:0] nc1, n, root, cur_eff;
	logic item_go, load_go, load_wr, dec_go, step, take;
	logic [EW-1:0] ent;
	logic [IDX_W-1:0] pos;
	logic bad, leaf, last;

	function automatic kids_t child_pair(input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] cnt, input logic [IDX_W-1:0] rt);
		kids_t k;
		k.pos0 = l;
		k.pos1 = r;
		k.bad0 = (l == NULL_CHILD) || (l >= cnt);
		k.bad1 = (r == NULL_CHILD) || (r >= cnt);
		if (cnt == 9'd1) begin
			k.pos0 = rt;
			k.bad0 = 1'b0;
			k.bad1 = 1'b1;
		end
		return k;
	endfunction

	assign nc1 = (node_count_q == '0) ? 9'd1 : node_count_q;
	assign n = (32'(nc1) > MAX_NODES) ? 9'(MAX_NODES) : nc1;
	assign root = n - 9'd1;
	assign cur_eff = (at_root_q || current_node_q >= n) ? root : current_node_q;

	assign item_stall = (item.operation == OP_DECODE) &&
		(sv_q || (!halted_q && !(seq_q == SEQ_RUN && pf_ok_q)));
	assign item_go = item_valid && !item_stall;
	assign load_go = item_go && (item.operation == OP_LOAD);
	assign load_wr = load_go && (32'(item.node_index) < MAX_NODES);
	assign dec_go = item_go && (item.operation == OP_DECODE);
	assign step = dec_go && !halted_q;
	assign take = rv_q && !result_stall;

	assign ent = item.coded_bit ? rd1_q : rd0_q;
	assign pos = item.coded_bit ? kids_q.pos1 : kids_q.pos0;
	assign bad = item.coded_bit ? kids_q.bad1 : kids_q.bad0;
	assign leaf = ent[SYMBOL_BITS];
	assign last = (cnt_q == exp_m1_q);

	always_comb begin
		res_new.symbol = '0;
		res_new.status = ST_NONE;
		if (halted_q) begin
			res_new.status = ST_HALTED;
		end else if (bad) begin
			res_new.status = ST_CORRUPT;
		end else if (leaf) begin
			res_new.symbol = SYM_W'(ent[SYMBOL_BITS-1:0]);
			res_new.status = last ? ST_LAST : ST_SYMBOL;
		end
	end

	always_comb begin
		seq_d = seq_q;
		pf_ok_d = pf_ok_q;
		kids_d = kids_q;
		root_l_d = root_l_q;
		root_r_d = root_r_q;
		raddr0 = AW'(kids_q.pos0);
		raddr1 = AW'(kids_q.pos1);
		cnt_d = cnt_q;
		halted_d = halted_q;
		current_node_d = current_node_q;
		at_root_d = at_root_q;
		unique case (seq_q)
			SEQ_ROOT: begin
				raddr0 = AW'(root);
				raddr1 = AW'(cur_eff);
				seq_d = SEQ_KIDS;
				pf_ok_d = 1'b0;
			end
			SEQ_KIDS: begin
				kids_d = child_pair(rd1_q[EW-1 -: IDX_W], rd1_q[EW-1-IDX_W -: IDX_W], n, root);
				root_l_d = rd0_q[EW-1 -: IDX_W];
				root_r_d = rd0_q[EW-1-IDX_W -: IDX_W];
				raddr0 = AW'(kids_d.pos0);
				raddr1 = AW'(kids_d.pos1);
				seq_d = SEQ_RUN;
				pf_ok_d = !load_wr;
			end
			SEQ_RUN: begin
				if (step) begin
					if (!bad) begin
						if (leaf) begin
							kids_d = child_pair(root_l_q, root_r_q, n, root);
						end else begin
							kids_d = child_pair(ent[EW-1 -: IDX_W], ent[EW-1-IDX_W -: IDX_W], n,
								root);
						end
						raddr0 = AW'(kids_d.pos0);
						raddr1 = AW'(kids_d.pos1);
					end
					pf_ok_d = 1'b1;
				end else if (load_wr) begin
					if (item.node_index == cur_eff) begin
						kids_d = child_pair(item.left_child, item.right_child, n, root);
					end
					if (item.node_index == root) begin
						root_l_d = item.left_child;
						root_r_d = item.right_child;
					end
					pf_ok_d = 1'b0;
				end else begin
					pf_ok_d = 1'b1;
				end
			end
			default: begin
				seq_d = SEQ_ROOT;
				pf_ok_d = 1'b0;
			end
		endcase
		if (load_wr && seq_q != SEQ_RUN) begin
			seq_d = SEQ_ROOT;
		end
		if (wr_en) begin
			seq_d = SEQ_ROOT;
			pf_ok_d = 1'b0;
		end
		if (step) begin
			if (bad) begin
				halted_d = 1'b1;
			end else if (leaf) begin
				current_node_d = '0;
				at_root_d = 1'b1;
				cnt_d = cnt_q + 48'd1;
				if (last) begin
					halted_d = 1'b1;
				end
			end else begin
				current_node_d = pos;
				at_root_d = (pos == root);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[AW'(item.node_index)] <= {item.left_child, item.right_child, item.leaf_flag,
				SYMBOL_BITS'(item.leaf_symbol)};
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 9'd1;
			exp_m1_q <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_NODE_COUNT: node_count_q <= IDX_W'(wr_data);
				CFG_EXPECTED: exp_m1_q <= wr_data - 48'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_ROOT;
			pf_ok_q <= 1'b0;
			cnt_q <= '0;
			halted_q <= 1'b0;
			current_node_q <= '0;
			at_root_q <= 1'b1;
		end else begin
			seq_q <= seq_d;
			pf_ok_q <= pf_ok_d;
			cnt_q <= cnt_d;
			halted_q <= halted_d;
			current_node_q <= current_node_d;
			at_root_q <= at_root_d;
		end
	end

	always_ff @(posedge clk) begin
		kids_q <= kids_d;
		root_l_q <= root_l_d;
		root_r_q <= root_r_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (dec_go) begin
			if (!rv_q || take) begin
				rv_q <= 1'b1;
			end else begin
				sv_q <= 1'b1;
			end
		end else if (take) begin
			if (sv_q) begin
				sv_q <= 1'b0;
			end else begin
				rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			if (!rv_q || take) begin
				res_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (take && sv_q) begin
			res_q <= skid_q;
		end
	end

	assign result_valid = rv_q;
	assign result = res_q;

	a_step_ready: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (seq_q == SEQ_RUN && pf_ok_q))
		else $error("Decode step taken without valid prefetched children.");

	a_corrupt_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && bad) |=> halted_q)
		else $error("Corrupt walk did not halt the decoder.");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> rv_q)
		else $error("Skid entry held while the output register is empty.");

	a_cfg_refetch: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (seq_q == SEQ_ROOT && !pf_ok_q))
		else $error("Register write did not restart the root fetch.");

	a_load_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(load_wr && seq_q == SEQ_RUN) |=> !pf_ok_q)
		else $error("Load did not invalidate the prefetched children.");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman tree bit decoder. Trees of many sizes
// are loaded node by node and walked with random coded bits, while nodes are
// rewritten between decodes. The bench predicts every symbol and status in
// order and compares each result transfer with the oldest prediction. The run
// ends with a halt, by last symbol or by corrupt input, and decodes after it.
// ----------------------------------------------------------------------------
module tb;
	import htbd_pkg::*;

	localparam int MAX_NODES = 512;
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	huffman_tree_bit_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #2 clk = ~clk;

	// Node store and walk state as the decoder should hold them.
	logic [IDX_W-1:0] store_left [MAX_NODES];
	logic [IDX_W-1:0] store_right [MAX_NODES];
	logic store_leaf [MAX_NODES];
	logic [SYM_W-1:0] store_sym [MAX_NODES];
	logic [IDX_W-1:0] walk_node = '0;
	logic walk_at_root = 1'b1;
	logic [CNT_W-1:0] decoded_count = '0;
	logic stopped = 1'b0;
	logic [IDX_W-1:0] cfg_nodes = 9'd1;
	logic [CFG_W-1:0] cfg_total = '0;

	// The tree as the stimulus side builds it, and where the walk stands.
	int tree_left [MAX_NODES];
	int tree_right [MAX_NODES];
	int tree_leaf [MAX_NODES];
	int tree_sym [MAX_NODES];
	int gen_n = 1;
	int gen_root = 0;
	int gen_pos = 0;
	int gen_syms = 0;

	item_t items_pending [$];
	result_t symbols_due [$];
	result_t want;
	int items_queued = 0;
	int items_taken = 0;
	int n_errors = 0;
	int n_results = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int seg_left = 0;
	int hold_left = 0;
	int next_hold_at = 60;
	int tick = 0;
	int quiet_cycles = 0;

	task automatic predict_symbol(input item_t it);
		int n;
		int cur;
		logic [IDX_W-1:0] pos;
		result_t r;
		if (it.operation == OP_LOAD) begin
			store_left[it.node_index] = it.left_child;
			store_right[it.node_index] = it.right_child;
			store_leaf[it.node_index] = it.leaf_flag;
			store_sym[it.node_index] = it.leaf_symbol;
			return;
		end
		r.symbol = '0;
		r.status = ST_HALTED;
		if (!stopped) begin
			n = (cfg_nodes == '0) ? 1 : int'(cfg_nodes);
			if (n == 1 && it.coded_bit) begin
				stopped = 1'b1;
				r.status = ST_CORRUPT;
			end else begin
				if (n == 1) begin
					pos = '0;
				end else begin
					cur = (walk_at_root || int'(walk_node) >= n) ? n - 1 : int'(walk_node);
					pos = it.coded_bit ? store_right[cur] : store_left[cur];
				end
				if (n > 1 && (pos == NULL_CHILD || int'(pos) >= n)) begin
					stopped = 1'b1;
					r.status = ST_CORRUPT;
				end else if (store_leaf[pos]) begin
					walk_node = '0;
					walk_at_root = 1'b1;
					decoded_count = decoded_count + CNT_W'(1);
					r.symbol = store_sym[pos];
					if (decoded_count == cfg_total) begin
						stopped = 1'b1;
						r.status = ST_LAST;
					end else begin
						r.status = ST_SYMBOL;
					end
				end else begin
					walk_node = pos;
					walk_at_root = (int'(pos) == n - 1);
					r.status = ST_NONE;
				end
			end
		end
		symbols_due = {symbols_due, r};
	endtask

	function automatic item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	task automatic push_load(input int idx);
		item_t it;
		it = random_item();
		it.operation = OP_LOAD;
		it.node_index = IDX_W'(idx);
		it.left_child = IDX_W'(tree_left[idx]);
		it.right_child = IDX_W'(tree_right[idx]);
		it.leaf_flag = 1'(tree_leaf[idx]);
		it.leaf_symbol = SYM_W'(tree_sym[idx]);
		items_pending = {items_pending, it};
		items_queued++;
	endtask

	task automatic push_bit(input logic b);
		item_t it;
		it = random_item();
		it.operation = OP_DECODE;
		it.coded_bit = b;
		items_pending = {items_pending, it};
		items_queued++;
	endtask

	task automatic set_node(input int idx, input int l, input int r, input int leaf,
			input int sym);
		tree_left[idx] = l;
		tree_right[idx] = r;
		tree_leaf[idx] = leaf;
		tree_sym[idx] = sym;
		push_load(idx);
	endtask

	task automatic grow_leaf(input int idx, input int lim);
		tree_leaf[idx] = 1;
		tree_sym[idx] = $urandom_range(0, 255);
		tree_left[idx] = $urandom_range(0, lim);
		tree_right[idx] = $urandom_range(0, lim);
	endtask

	task automatic send_bit(input int bias);
		logic b;
		int nxt;
		b = ($urandom_range(0, 99) < bias);
		if (gen_n < 2) begin
			push_bit(1'b0);
		end else begin
			push_bit(b);
			nxt = b ? tree_right[gen_pos] : tree_left[gen_pos];
			if (tree_leaf[nxt] != 0) begin
				gen_pos = gen_root;
				gen_syms++;
			end else begin
				gen_pos = nxt;
			end
		end
	endtask

	// Rewrites one node without breaking the walk: new symbols on leaves,
	// swapped children on inner nodes, anything on nodes outside the tree.
	task automatic touch_node();
		int idx;
		int t;
		if (gen_n < 2 && $urandom_range(0, 1) == 0) begin
			grow_leaf(0, 511);
			tree_leaf[0] = $urandom_range(0, 1);
			push_load(0);
		end else if (gen_n < 2 || $urandom_range(0, 3) == 0) begin
			idx = $urandom_range(gen_n, 511);
			grow_leaf(idx, 511);
			tree_leaf[idx] = $urandom_range(0, 1);
			push_load(idx);
		end else begin
			idx = $urandom_range(0, gen_n - 1);
			if (tree_leaf[idx] != 0) begin
				grow_leaf(idx, (idx == gen_pos) ? gen_n - 1 : 511);
			end else begin
				t = tree_left[idx];
				tree_left[idx] = tree_right[idx];
				tree_right[idx] = t;
			end
			push_load(idx);
		end
	endtask

	task automatic plant_tree(input int n);
		int order [MAX_NODES];
		int leaves [$];
		int k;
		int j;
		int x;
		int used;
		int nf;
		gen_n = n;
		gen_root = n - 1;
		for (k = 0; k < n - 1; k++) order[k] = k;
		for (k = n - 2; k > 0; k--) begin
			j = $urandom_range(0, k);
			x = order[k];
			order[k] = order[j];
			order[j] = x;
		end
		if (n == 1) begin
			grow_leaf(0, 511);
			tree_leaf[0] = $urandom_range(0, 1);
		end else if (n == 2) begin
			grow_leaf(0, 511);
			grow_leaf(1, 1);
			tree_leaf[1] = 0;
		end else begin
			grow_leaf(gen_root, 511);
			leaves = {leaves, gen_root};
			used = 1;
			nf = 0;
			while (used + 1 < n) begin
				k = $urandom_range(0, 1) ? leaves.size() - 1 : $urandom_range(0, leaves.size() - 1);
				x = leaves[k];
				leaves.delete(k);
				tree_leaf[x] = 0;
				tree_left[x] = order[nf];
				tree_right[x] = order[nf + 1];
				grow_leaf(order[nf], 511);
				grow_leaf(order[nf + 1], 511);
				leaves = {leaves, order[nf]};
				leaves = {leaves, order[nf + 1]};
				nf += 2;
				used += 2;
			end
			if (used < n) grow_leaf(order[nf], 511);
		end
		// A walk left inside the previous tree resumes from a node of this one,
		// so that node must lead somewhere valid even if it is a leaf here.
		gen_pos = gen_root;
		if (n > 1 && !walk_at_root && int'(walk_node) < n) begin
			gen_pos = int'(walk_node);
			if (tree_leaf[gen_pos] != 0) begin
				tree_left[gen_pos] = $urandom_range(0, n - 1);
				tree_right[gen_pos] = $urandom_range(0, n - 1);
			end
		end
		for (k = 0; k < n - 1; k++) push_load(order[k]);
		push_load(gen_root);
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || symbols_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_NODE_COUNT) cfg_nodes = val[IDX_W-1:0];
		else cfg_total = val;
	endtask

	// Totals that the count cannot reach within the run.
	function automatic logic [CFG_W-1:0] safe_total();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return {1'b1, 15'($urandom), $urandom};
			default: return decoded_count;
		endcase
	endfunction

	task automatic start_phase(input int cnt, input int to_last);
		wait_idle();
		cfg_write(CFG_NODE_COUNT, CFG_W'(cnt));
		if (to_last > 0) cfg_write(CFG_EXPECTED, decoded_count + CNT_W'(to_last));
		else cfg_write(CFG_EXPECTED, safe_total());
		plant_tree((cnt == 0) ? 1 : cnt);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predict_symbol(item);
				items_taken++;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (items_pending.size() != 0) begin
					item <= items_pending.pop_front();
					item_valid <= 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 60);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				n_results++;
				if (symbols_due.size() == 0) begin
					$error("result with nothing expected: symbol %0h status %0d",
						result.symbol, result.status);
					n_errors++;
				end else begin
					want = symbols_due.pop_front();
					if (result.symbol !== want.symbol) begin
						$error("symbol: expected %0h, got %0h", want.symbol, result.symbol);
						n_errors++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						n_errors++;
					end
				end
			end
			tick++;
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 200);
				stall_mode = $urandom_range(0, 3);
			end else begin
				seg_left--;
			end
			if (hold_left == 0 && n_results >= next_hold_at) begin
				hold_left = 120;
				next_hold_at += 640;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 2) == 0);
					2: result_stall <= (tick % 5 < 2);
					default: result_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int cnt;
		int r;
		int bias;
		int mode;
		int k;
		int idx;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// One-node tree with a zero count, then a three-node tree.
		cfg_write(CFG_NODE_COUNT, '0);
		cfg_write(CFG_EXPECTED, '1);
		gen_n = 1;
		set_node(0, 511, 511, 1, 255);
		push_bit(1'b0);
		push_bit(1'b0);
		set_node(0, 0, 0, 0, 0);
		push_bit(1'b0);
		set_node(511, 511, 511, 1, 255);
		set_node(0, 0, 511, 1, 0);
		push_bit(1'b0);
		wait_idle();
		cfg_write(CFG_NODE_COUNT, CFG_W'(3));
		set_node(0, 0, 511, 1, 0);
		set_node(1, 511, 0, 1, 255);
		set_node(2, 0, 1, 0, 165);
		push_bit(1'b0);
		push_bit(1'b1);
		push_bit(1'b1);
		push_bit(1'b0);
		push_bit(1'b0);

		ph = 0;
		while (items_queued < 1560) begin
			case (ph)
				0: cnt = 2;
				1: cnt = 511;
				2: cnt = 1;
				3: cnt = 0;
				default: begin
					r = $urandom_range(0, 9);
					if (r < 7) cnt = $urandom_range(3, 31);
					else if (r < 9) cnt = $urandom_range(32, 120);
					else cnt = $urandom_range(1, 2);
				end
			endcase
			start_phase(cnt, 0);
			r = $urandom_range(0, 2);
			bias = (r == 0) ? 10 : (r == 1) ? 50 : 90;
			repeat ($urandom_range(40, 160)) begin
				if ($urandom_range(0, 15) == 0) touch_node();
				else send_bit(bias);
			end
			ph++;
		end

		// Closing phase: stop on the last symbol, a bad child or a one-node 1 bit.
		mode = $urandom_range(0, 2);
		k = $urandom_range(1, 4);
		start_phase($urandom_range(3, 20), (mode == 0) ? k : 0);
		if (mode == 0) begin
			gen_syms = 0;
			while (gen_syms < k) send_bit(50);
		end else begin
			repeat (10) send_bit(50);
			while (gen_pos != gen_root) send_bit(50);
			if (mode == 1) begin
				tree_left[gen_root] = $urandom_range(0, 1) ? 511 : $urandom_range(gen_n, 510);
				push_load(gen_root);
				push_bit(1'b0);
			end else begin
				wait_idle();
				cfg_write(CFG_NODE_COUNT, CFG_W'(1));
				push_bit(1'b1);
			end
		end
		repeat (12) begin
			if ($urandom_range(0, 2) == 0) begin
				idx = $urandom_range(0, 511);
				grow_leaf(idx, 511);
				tree_leaf[idx] = $urandom_range(0, 1);
				push_load(idx);
			end else begin
				push_bit(1'($urandom_range(0, 1)));
			end
		end
		wait_idle();
		repeat (4) @(posedge clk);
		if (n_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/htbd_pkg.sv
rtl/huffman_tree_bit_decoder.sv
verif/tb.sv
